// File: rtl/core/spc_pkg.sv
package spc_pkg;

   // shape kind codes as carried in the request word
   typedef enum logic [1:0] {
      KIND_POINT   = 2'd0,
      KIND_RECT    = 2'd1,
      KIND_CIRCLE  = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

   // decoded shape kind
   typedef struct packed {
      logic is_rect;
      logic is_circle;
   } kind_dec_type;

   // occupancy flags of the queue between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // entries held between front and back
   localparam int QUEUE_DEPTH = 2;

endpackage

// File: rtl/core/spc_req_if.sv
interface spc_req_if #(
   parameter int COORD_WIDTH = 16
) ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    a_kind;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic [COORD_WIDTH-2:0]        a_w;
   logic [COORD_WIDTH-2:0]        a_h;
   logic [COORD_WIDTH-2:0]        a_r;
   logic [1:0]                    b_kind;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic [COORD_WIDTH-2:0]        b_w;
   logic [COORD_WIDTH-2:0]        b_h;
   logic [COORD_WIDTH-2:0]        b_r;

   modport source (
      output valid, a_kind, a_x, a_y, a_w, a_h, a_r,
      output b_kind, b_x, b_y, b_w, b_h, b_r,
      input  ready
   );

   modport sink (
      input  valid, a_kind, a_x, a_y, a_w, a_h, a_r,
      input  b_kind, b_x, b_y, b_w, b_h, b_r,
      output ready
   );
endinterface

// File: rtl/core/spc_rsp_if.sv
interface spc_rsp_if ();
   logic valid;
   logic ready;
   logic hit;
   logic kind_error;

   modport source (
      output valid, hit, kind_error,
      input  ready
   );

   modport sink (
      input  valid, hit, kind_error,
      output ready
   );
endinterface

// File: rtl/core/spc_front.sv
module spc_front #(
   parameter int COORD_WIDTH = 16
) (
   spc_req_if.sink                req,
   input  spc_pkg::q_status_type  q_stat,
   output logic                   push,
   output logic [9*COORD_WIDTH+8:0] push_data
);
   import spc_pkg::*;

   localparam int CW = COORD_WIDTH;

   kind_dec_type          a_dec, b_dec;
   logic                  err;
   logic signed [CW:0]    ax_lo, ax_hi, ay_lo, ay_hi;
   logic signed [CW:0]    bx_lo, bx_hi, by_lo, by_hi;
   logic [CW-1:0]         r_sum;

   function automatic kind_dec_type decode(input kind_type k);
      kind_dec_type d;
      d = '0;
      unique case (k)
         KIND_RECT:   d.is_rect   = 1'b1;
         KIND_CIRCLE: d.is_circle = 1'b1;
         default:     d = '0;
      endcase
      return d;
   endfunction

   // take a word whenever the queue has room
   assign req.ready = !q_stat.full;
   assign push      = req.valid && !q_stat.full;

   // classify both shapes
   always_comb begin
      a_dec = decode(kind_type'(req.a_kind));
      b_dec = decode(kind_type'(req.b_kind));
      err   = (kind_type'(req.a_kind) == KIND_INVALID) ||
              (kind_type'(req.b_kind) == KIND_INVALID);
   end

   // every shape becomes an interval per axis; points and circles are degenerate
   always_comb begin
      ax_lo = (CW+1)'(req.a_x);
      ay_lo = (CW+1)'(req.a_y);
      bx_lo = (CW+1)'(req.b_x);
      by_lo = (CW+1)'(req.b_y);
      ax_hi = ax_lo + (a_dec.is_rect ? {2'b00, req.a_w} : '0);
      ay_hi = ay_lo + (a_dec.is_rect ? {2'b00, req.a_h} : '0);
      bx_hi = bx_lo + (b_dec.is_rect ? {2'b00, req.b_w} : '0);
      by_hi = by_lo + (b_dec.is_rect ? {2'b00, req.b_h} : '0);
      // radii add; two circles reduce to a point against the summed radius
      r_sum = (a_dec.is_circle ? {1'b0, req.a_r} : '0) +
              (b_dec.is_circle ? {1'b0, req.b_r} : '0);
   end

   assign push_data = {err, r_sum, ax_lo, ax_hi, ay_lo, ay_hi,
                       bx_lo, bx_hi, by_lo, by_hi};

endmodule

// File: rtl/core/spc_queue.sv
module spc_queue #(
   parameter int DATA_W = 153
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_W-1:0]     push_data,
   input  logic                  pop,
   output logic [DATA_W-1:0]     pop_data,
   output spc_pkg::q_status_type q_stat
);
   import spc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_data     = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/spc_back.sv
module spc_back #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spc_pkg::q_status_type     q_stat,
   input  logic [9*COORD_WIDTH+8:0]  pop_data,
   output logic                      pop,
   spc_rsp_if.source                 rsp
);
   import spc_pkg::*;

   localparam int CW = COORD_WIDTH;

   logic                q_err;
   logic [CW-1:0]       q_r;
   logic signed [CW:0]  ax_lo, ax_hi, ay_lo, ay_hi;
   logic signed [CW:0]  bx_lo, bx_hi, by_lo, by_hi;
   logic                adv;

   // gap stage
   logic                v1_ff, v1_in;
   logic                err1_ff, err1_in;
   logic [CW-1:0]       gx1_ff, gx1_in, gy1_ff, gy1_in, r1_ff, r1_in;
   // square stage
   logic                v2_ff, v2_in;
   logic                err2_ff, err2_in;
   logic [2*CW-1:0]     gx2_ff, gx2_in, gy2_ff, gy2_in, r2_ff, r2_in;
   // output register
   logic                out_valid_ff, out_valid_in;
   logic                hit_ff, hit_in;
   logic                kerr_ff, kerr_in;
   logic [2*CW:0]       dist2;

   // distance between two closed intervals, zero when they overlap;
   // both differences cannot be positive at once since lo <= hi
   function automatic logic [CW-1:0] axis_gap(input logic signed [CW:0] lo1,
                                              input logic signed [CW:0] hi1,
                                              input logic signed [CW:0] lo2,
                                              input logic signed [CW:0] hi2);
      logic signed [CW+1:0] d1, d2;
      d1 = (CW+2)'(lo1) - (CW+2)'(hi2);
      d2 = (CW+2)'(lo2) - (CW+2)'(hi1);
      if (!d1[CW+1]) begin
         return d1[CW-1:0];
      end else if (!d2[CW+1]) begin
         return d2[CW-1:0];
      end
      return '0;
   endfunction

   assign {q_err, q_r, ax_lo, ax_hi, ay_lo, ay_hi,
           bx_lo, bx_hi, by_lo, by_hi} = pop_data;

   // whole back end moves when the output register is free or being drained
   assign adv = !out_valid_ff || rsp.ready;
   assign pop = adv && !q_stat.empty;

   always_comb begin
      v1_in   = adv ? !q_stat.empty : v1_ff;
      err1_in = q_err;
      gx1_in  = axis_gap(ax_lo, ax_hi, bx_lo, bx_hi);
      gy1_in  = axis_gap(ay_lo, ay_hi, by_lo, by_hi);
      r1_in   = q_r;
   end

   always_comb begin
      v2_in   = adv ? v1_ff : v2_ff;
      err2_in = err1_ff;
      gx2_in  = {{CW{1'b0}}, gx1_ff} * {{CW{1'b0}}, gx1_ff};
      gy2_in  = {{CW{1'b0}}, gy1_ff} * {{CW{1'b0}}, gy1_ff};
      r2_in   = {{CW{1'b0}}, r1_ff} * {{CW{1'b0}}, r1_ff};
   end

   // squared gap against squared radius, boundary counts as a hit
   always_comb begin
      dist2        = {1'b0, gx2_ff} + {1'b0, gy2_ff};
      out_valid_in = adv ? v2_ff : out_valid_ff;
      hit_in       = !err2_ff && (dist2 <= {1'b0, r2_ff});
      kerr_in      = err2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         err1_ff <= err1_in;
         gx1_ff  <= gx1_in;
         gy1_ff  <= gy1_in;
         r1_ff   <= r1_in;
         err2_ff <= err2_in;
         gx2_ff  <= gx2_in;
         gy2_ff  <= gy2_in;
         r2_ff   <= r2_in;
         hit_ff  <= hit_in;
         kerr_ff <= kerr_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.hit        = hit_ff;
   assign rsp.kind_error = kerr_ff;

endmodule

// File: rtl/core/shape_pair_collision_test_top.sv
// Shape pair collision test.
// req channel: one word per shape pair, each shape a point, an axis-aligned
// rectangle (corner plus width and height) or a circle (centre plus radius),
// signed fixed-point coordinates. rsp channel: one word per request word,
// hit set when the shapes overlap or touch, kind_error set (and hit clear)
// when either kind is the invalid code.
// Both channels use valid/ready; a word moves when both are high.
// Throughput: one pair per cycle while the receiver does not stall. The result
// word passes through the queue, gap stage, square stage and output register
// after the request word is taken, and is held while the receiver stalls.
// The front classifies and turns each shape into per-axis intervals and
// pushes into a two-entry queue; the back computes per-axis gaps, squares
// them with one multiplier per term and compares against the squared radius.
// While rsp.ready is low the back holds; the queue fills and req.ready drops
// once it holds two words.
// Synchronous reset empties the queue and clears all valid flags.
module shape_pair_collision_test_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic   clock,
   input  logic   reset,
   spc_req_if.sink   req,
   spc_rsp_if.source rsp
);
   import spc_pkg::*;

   localparam int EW = 9 * COORD_WIDTH + 9;

   q_status_type  q_stat;
   logic          push, pop;
   logic [EW-1:0] push_data, pop_data;

   spc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .req       (req),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   spc_queue #(.DATA_W(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   spc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp      (rsp)
   );

   // an invalid kind never reports a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.hit && rsp.kind_error))
      else $error("hit reported together with kind error");

   // reset leaves nothing queued and nothing on the output
   assert property (@(posedge clock)
      reset |=> (q_stat.empty && !rsp.valid))
      else $error("state left over after reset");

   // queue cannot be both full and empty
   assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue flags inconsistent");

   // nothing is popped from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule
